FILE: hw/rtl/hdlc_nrzi_deframer_fcs_defines.svh
// ----------------------------------------------------------------------------
// HDLC deframer assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef HDLC_NRZI_DEFRAMER_FCS_DEFINES_SVH
`define HDLC_NRZI_DEFRAMER_FCS_DEFINES_SVH

// same-cycle implication
`define HDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hdf_pkg.sv
// ----------------------------------------------------------------------------
// HDLC deframer package
// Codes, constants and the result record shared by the deframer files.
// ----------------------------------------------------------------------------
package hdf_pkg;

  typedef enum logic {
    KindData = 1'b0,
    KindEnd  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    StGood       = 3'd0,
    StBadFcs     = 3'd1,
    StShort      = 3'd2,
    StMisaligned = 3'd3,
    StStuffing   = 3'd4,
    StAborted    = 3'd5,
    StOverlength = 3'd6
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    status_e    status;
    logic       last;
  } res_t;

  // register indexes
  localparam logic RegMinFrameBytes = 1'b0;
  localparam logic RegMaxRawBits    = 1'b1;

  localparam logic [7:0]  MinFrameBytesReset = 8'd17;
  localparam logic [15:0] MaxRawBitsReset    = 16'd16384;

  localparam logic [15:0] FcsInit     = 16'hFFFF;
  localparam logic [15:0] FcsPoly     = 16'h8408;
  localparam logic [15:0] FcsResidue  = 16'hF0B8;
  localparam logic [7:0]  FlagPattern = 8'h7E;

  localparam logic [15:0] RawCountMax   = 16'hFFFF;
  localparam logic [12:0] ByteCountMax  = 13'h1FFF;
  localparam logic [12:0] MinBytesFloor = 13'd3;

  localparam int unsigned QueueDepth = 4;

endpackage

FILE: hw/rtl/hdf_in_if.sv
// ----------------------------------------------------------------------------
// HDLC deframer input channel
// One tone decision per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hdf_in_if;
  logic valid;
  logic ready;
  logic tone_is_mark;

  modport source (output valid, output tone_is_mark, input ready);
  modport sink   (input valid, input tone_is_mark, output ready);
endinterface

FILE: hw/rtl/hdf_out_if.sv
// ----------------------------------------------------------------------------
// HDLC deframer result channel
// One data byte or end-of-frame status per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hdf_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output kind, output data_byte, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input last, output ready);
endinterface

FILE: hw/rtl/hdlc_nrzi_deframer_fcs.sv
// ----------------------------------------------------------------------------
// HDLC NRZI deframer with FCS check
// NRZI decode, flag search, de-stuffing, byte packing and CRC-16/X.25 check.
// ----------------------------------------------------------------------------
// Takes one tone decision per ready cycle. Each accepted bit is processed in
// the cycle it is taken and its results (at most a data byte and an end
// status) drop into a small result queue, so results are registered after
// the bit and leave one per cycle. Input ready stays high while the queue has
// room for two results; with the result side always ready the block takes a
// bit every cycle. The queue depth (QDepth, at least 2) sets how many results
// may wait when the result side stalls. Registers sit at byte addresses 0
// (min_frame_bytes) and 4 (max_raw_bits); no clearing pass follows reset.
module hdlc_nrzi_deframer_fcs #(
  parameter int unsigned QDepth = hdf_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdf_in_if.sink      bit_i,
  hdf_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hdf_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic [7:0]  min_bytes_q;
  logic [15:0] max_bits_q;

  logic        prev_tone_q, prev_tone_d;
  logic [7:0]  window_q, window_d;
  logic [3:0]  fill_q, fill_d;
  logic        inside_q, inside_d;
  logic [2:0]  ones_q, ones_d;
  logic [15:0] raw_cnt_q, raw_cnt_d;
  logic [2:0]  stuff_q, stuff_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  bitpos_q, bitpos_d;
  logic [12:0] bytes_q, bytes_d;
  logic [15:0] crc_q, crc_d;
  logic        ferr_q, ferr_d;

  logic        accept;
  logic        tone;
  logic        nrzi_bit;
  logic        cbit;
  logic        take_bit;
  logic        flag_hit;
  logic [2:0]  ones_next;
  logic [7:0]  byte_full;
  logic        push_data;
  logic        push_end;
  status_e     end_status;
  res_t        entry0, entry1;
  logic [1:0]  n_push;

  res_t            queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxRawBits) ? {16'd0, max_bits_q} : {24'd0, min_bytes_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bytes_q <= MinFrameBytesReset;
      max_bits_q  <= MaxRawBitsReset;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegMinFrameBytes) begin
        min_bytes_q <= pwdata[7:0];
      end else begin
        max_bits_q <= pwdata[15:0];
      end
    end
  end

  assign accept   = bit_i.valid && bit_i.ready;
  assign tone     = bit_i.tone_is_mark;
  assign nrzi_bit = (tone == prev_tone_q);
  assign cbit     = window_q[0];

  always_comb begin
    prev_tone_d = prev_tone_q;
    window_d    = window_q;
    fill_d      = fill_q;
    inside_d    = inside_q;
    ones_d      = ones_q;
    raw_cnt_d   = raw_cnt_q;
    stuff_d     = stuff_q;
    shift_d     = shift_q;
    bitpos_d    = bitpos_q;
    bytes_d     = bytes_q;
    crc_d       = crc_q;
    ferr_d      = ferr_q;
    take_bit    = 1'b0;
    flag_hit    = 1'b0;
    ones_next   = '0;
    byte_full   = shift_q;
    push_data   = 1'b0;
    push_end    = 1'b0;
    end_status  = StGood;

    if (accept) begin
      prev_tone_d = tone;

      // de-stuff and commit the bit leaving the flag window
      if (inside_q && (raw_cnt_q >= 16'd8) && !ferr_q) begin
        if (cbit) begin
          stuff_d = stuff_q + 3'd1;
          if (stuff_q >= 3'd5) begin
            ferr_d = 1'b1;
          end else begin
            take_bit = 1'b1;
          end
        end else begin
          stuff_d  = 3'd0;
          take_bit = (stuff_q != 3'd5);
        end
      end

      if (take_bit) begin
        crc_d = (crc_q >> 1) ^ ((crc_q[0] ^ cbit) ? FcsPoly : 16'h0000);
        byte_full[bitpos_q] = shift_q[bitpos_q] | cbit;
        if (bitpos_q == 3'd7) begin
          push_data = 1'b1;
          if (bytes_q != ByteCountMax) begin
            bytes_d = bytes_q + 13'd1;
          end
          shift_d  = '0;
          bitpos_d = '0;
        end else begin
          shift_d  = byte_full;
          bitpos_d = bitpos_q + 3'd1;
        end
      end

      if (inside_q && (raw_cnt_q != RawCountMax)) begin
        raw_cnt_d = raw_cnt_q + 16'd1;
      end

      window_d = {nrzi_bit, window_q[7:1]};
      if (fill_q < 4'd8) begin
        fill_d = fill_q + 4'd1;
      end
      flag_hit = (fill_d >= 4'd8) && (window_d == FlagPattern);

      if (ferr_d) begin
        end_status = StStuffing;
      end else if (bitpos_d != 3'd0) begin
        end_status = StMisaligned;
      end else if ((bytes_d < {5'd0, min_bytes_q}) || (bytes_d < MinBytesFloor)) begin
        end_status = StShort;
      end else if (crc_d == FcsResidue) begin
        end_status = StGood;
      end else begin
        end_status = StBadFcs;
      end

      if (flag_hit) begin
        push_end = inside_q && (raw_cnt_d > 16'd8);
        inside_d = 1'b1;
        ones_d   = '0;
      end else begin
        ones_next = nrzi_bit ? ((ones_q < 3'd7) ? ones_q + 3'd1 : ones_q) : 3'd0;
        if (ones_next == 3'd7) begin
          push_end   = inside_q;
          end_status = StAborted;
          inside_d   = 1'b0;
          ones_d     = '0;
          window_d   = '0;
          fill_d     = '0;
        end else begin
          ones_d = ones_next;
          if (inside_q && (raw_cnt_d > max_bits_q)) begin
            push_end   = 1'b1;
            end_status = StOverlength;
            inside_d   = 1'b0;
          end
        end
      end

      // frame restart
      if (flag_hit || (ones_next == 3'd7) || push_end) begin
        raw_cnt_d = '0;
        stuff_d   = '0;
        shift_d   = '0;
        bitpos_d  = '0;
        bytes_d   = '0;
        crc_d     = FcsInit;
        ferr_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tone_q <= 1'b0;
      window_q    <= '0;
      fill_q      <= '0;
      inside_q    <= 1'b0;
      ones_q      <= '0;
      raw_cnt_q   <= '0;
      stuff_q     <= '0;
      shift_q     <= '0;
      bitpos_q    <= '0;
      bytes_q     <= '0;
      crc_q       <= FcsInit;
      ferr_q      <= 1'b0;
    end else begin
      prev_tone_q <= prev_tone_d;
      window_q    <= window_d;
      fill_q      <= fill_d;
      inside_q    <= inside_d;
      ones_q      <= ones_d;
      raw_cnt_q   <= raw_cnt_d;
      stuff_q     <= stuff_d;
      shift_q     <= shift_d;
      bitpos_q    <= bitpos_d;
      bytes_q     <= bytes_d;
      crc_q       <= crc_d;
      ferr_q      <= ferr_d;
    end
  end

  // result queue
  always_comb begin
    entry0 = '{kind: KindData, data_byte: byte_full, status: StGood, last: !push_end};
    entry1 = '{kind: KindEnd, data_byte: 8'd0, status: end_status, last: 1'b1};
    n_push = {1'b0, push_data} + {1'b0, push_end};
    if (!push_data) begin
      entry0 = entry1;
    end
  end

  assign pop         = res_o.valid && res_o.ready;
  assign res_o.valid = (cnt_q != '0);
  assign bit_i.ready = (cnt_q <= CntW'(QDepth - 2));

  assign res_o.kind      = queue_q[rd_ptr_q].kind;
  assign res_o.data_byte = queue_q[rd_ptr_q].data_byte;
  assign res_o.status    = queue_q[rd_ptr_q].status;
  assign res_o.last      = queue_q[rd_ptr_q].last;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= entry0;
    end
    if (n_push == 2'd2) begin
      queue_q[ptr_inc(wr_ptr_q)] <= entry1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (n_push == 2'd1) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end else if (n_push == 2'd2) begin
        wr_ptr_q <= ptr_inc(ptr_inc(wr_ptr_q));
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

endmodule

FILE: hw/rtl/hdf_checker.sv
// ----------------------------------------------------------------------------
// HDLC deframer port checker
// Concurrent checks on the result channel and configuration port.
// ----------------------------------------------------------------------------
`include "hdlc_nrzi_deframer_fcs_defines.svh"

module hdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid,
  input logic       res_ready,
  input logic       res_kind,
  input logic [7:0] res_data_byte,
  input logic [2:0] res_status,
  input logic       res_last,
  input logic       pready
);
  import hdf_pkg::*;

  `HDF_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
    res_valid && $stable({res_kind, res_data_byte, res_status, res_last}),
    "stalled request changed")
  `HDF_ASSERT_NOW(a_end_zero_byte, res_valid && (res_kind == KindEnd),
    (res_data_byte == 8'd0) && res_last, "end status carries a byte or is not last")
  `HDF_ASSERT_NOW(a_data_status, res_valid && (res_kind == KindData),
    res_status == StGood, "data byte carries a status")
  `HDF_ASSERT_NOW(a_pready, 1'b1, pready, "configuration port stalled")

endmodule

bind hdlc_nrzi_deframer_fcs hdf_checker u_hdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid     (res_o.valid),
  .res_ready     (res_o.ready),
  .res_kind      (res_o.kind),
  .res_data_byte (res_o.data_byte),
  .res_status    (res_o.status),
  .res_last      (res_o.last),
  .pready        (pready)
);
